// ===== hdl/rbds_pkg.sv =====
// shared types, status codes and the three-letter call sign table
package rbds_pkg;

    // status codes of a result transaction
    localparam logic [1:0] ST_CALC = 2'd0;
    localparam logic [1:0] ST_HIT  = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;
    localparam logic [1:0] ST_NONE = 2'd3;

    // code block limits
    localparam logic [15:0] K_FIRST = 16'h1000;
    localparam logic [15:0] W_FIRST = 16'h54A8;
    localparam logic [15:0] W_LAST  = 16'h994F;
    localparam logic [15:0] T_FIRST = 16'h9950;
    localparam logic [15:0] T_LAST  = 16'h99B9;

    // ascii letters in use
    localparam logic [6:0] CH_A = 7'h41;
    localparam logic [6:0] CH_K = 7'h4B;
    localparam logic [6:0] CH_W = 7'h57;
    localparam logic [6:0] CH_Q = 7'h3F;

    // reciprocal constants for division by 676 and by 26
    localparam logic [14:0] RECIP_676 = 15'd24819;  // ceil(2^24 / 676)
    localparam int          SHIFT_676 = 24;
    localparam logic [11:0] RECIP_26  = 12'd2521;   // ceil(2^16 / 26)
    localparam int          SHIFT_26  = 16;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] letter_count;
        logic [6:0] letter_0;
        logic [6:0] letter_1;
        logic [6:0] letter_2;
        logic [6:0] letter_3;
    } t_result;

    typedef struct packed {
        logic        hit;
        logic [23:0] name;
    } t_lookup;

    // fixed three-letter call sign table
    function automatic t_lookup lookup_three(input logic [15:0] code);
        t_lookup r;
        r.hit = 1'b1;
        case (code)
            16'h99A5: r.name = "KBW";
            16'h99A6: r.name = "KCY";
            16'h9990: r.name = "KDB";
            16'h99A7: r.name = "KDF";
            16'h9950: r.name = "KEX";
            16'h9951: r.name = "KFH";
            16'h9952: r.name = "KFI";
            16'h9953: r.name = "KGA";
            16'h9991: r.name = "KGB";
            16'h9954: r.name = "KGO";
            16'h9955: r.name = "KGU";
            16'h9956: r.name = "KGW";
            16'h9957: r.name = "KGY";
            16'h99AA: r.name = "KHQ";
            16'h9958: r.name = "KID";
            16'h9959: r.name = "KIT";
            16'h995A: r.name = "KJR";
            16'h995B: r.name = "KLO";
            16'h995C: r.name = "KLZ";
            16'h995D: r.name = "KMA";
            16'h995E: r.name = "KMJ";
            16'h995F: r.name = "KNX";
            16'h9960: r.name = "KOA";
            16'h99AB: r.name = "KOB";
            16'h9992: r.name = "KOY";
            16'h9993: r.name = "KPQ";
            16'h9964: r.name = "KQV";
            16'h9994: r.name = "KSD";
            16'h9965: r.name = "KSL";
            16'h9966: r.name = "KUJ";
            16'h9995: r.name = "KUT";
            16'h9967: r.name = "KVI";
            16'h9968: r.name = "KWG";
            16'h9996: r.name = "KXL";
            16'h9997: r.name = "KXO";
            16'h996B: r.name = "KYW";
            16'h9999: r.name = "WBT";
            16'h996D: r.name = "WBZ";
            16'h996E: r.name = "WDZ";
            16'h996F: r.name = "WEW";
            16'h999A: r.name = "WGH";
            16'h9971: r.name = "WGL";
            16'h9972: r.name = "WGN";
            16'h9973: r.name = "WGR";
            16'h999B: r.name = "WGY";
            16'h9975: r.name = "WHA";
            16'h9976: r.name = "WHB";
            16'h9977: r.name = "WHK";
            16'h9978: r.name = "WHO";
            16'h999C: r.name = "WHP";
            16'h999D: r.name = "WIL";
            16'h997A: r.name = "WIP";
            16'h99B3: r.name = "WIS";
            16'h997B: r.name = "WJR";
            16'h99B4: r.name = "WJW";
            16'h99B5: r.name = "WJZ";
            16'h997C: r.name = "WKY";
            16'h997D: r.name = "WLS";
            16'h997E: r.name = "WLW";
            16'h999E: r.name = "WMC";
            16'h999F: r.name = "WMT";
            16'h9981: r.name = "WOC";
            16'h99A0: r.name = "WOI";
            16'h9983: r.name = "WOL";
            16'h9984: r.name = "WOR";
            16'h99A1: r.name = "WOW";
            16'h99B9: r.name = "WRC";
            16'h99A2: r.name = "WRR";
            16'h99A3: r.name = "WSB";
            16'h99A4: r.name = "WSM";
            16'h9988: r.name = "WWJ";
            16'h9989: r.name = "WWL";
            default: begin
                r.hit  = 1'b0;
                r.name = '0;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/rbds_decode.sv =====
// combinational decode of one pi code into a call sign result
module rbds_decode (
    input  logic [15:0]      i_pi_code,
    output rbds_pkg::t_result o_result
);
    import rbds_pkg::*;

    logic        is_k;
    logic        is_w;
    logic        is_t;
    logic [15:0] k_off_full;
    logic [15:0] w_off_full;
    logic [14:0] off;
    logic [29:0] hi_prod;
    logic [4:0]  hi;
    logic [14:0] hi_scaled;
    logic [9:0]  rem;
    logic [21:0] mid_prod;
    logic [4:0]  mid;
    logic [9:0]  mid_scaled;
    logic [4:0]  lo;
    logic [6:0]  first;
    t_lookup     tbl;

    // block classification
    assign is_k = (i_pi_code >= K_FIRST) && (i_pi_code < W_FIRST);
    assign is_w = (i_pi_code >= W_FIRST) && (i_pi_code <= W_LAST);
    assign is_t = (i_pi_code >= T_FIRST) && (i_pi_code <= T_LAST);

    // offset within the k or w block, below 26^3
    assign k_off_full = i_pi_code - K_FIRST;
    assign w_off_full = i_pi_code - W_FIRST;
    assign off   = is_k ? k_off_full[14:0] : w_off_full[14:0];
    assign first = is_k ? CH_K : CH_W;

    // first base-26 digit by reciprocal multiply
    assign hi_prod   = 30'(off) * 30'(RECIP_676);
    assign hi        = hi_prod[SHIFT_676 +: 5];
    assign hi_scaled = 15'(hi) * 15'd676;
    assign rem       = 10'(off - hi_scaled);

    // second and third digits from the remainder
    assign mid_prod   = 22'(rem) * 22'(RECIP_26);
    assign mid        = mid_prod[SHIFT_26 +: 5];
    assign mid_scaled = 10'(mid) * 10'd26;
    assign lo         = 5'(rem - mid_scaled);

    assign tbl = lookup_three(i_pi_code);

    // result selection
    always_comb begin
        o_result = '0;
        if (is_k || is_w) begin
            o_result.status       = ST_CALC;
            o_result.letter_count = 3'd4;
            o_result.letter_0     = first;
            o_result.letter_1     = CH_A + 7'(hi);
            o_result.letter_2     = CH_A + 7'(mid);
            o_result.letter_3     = CH_A + 7'(lo);
        end else if (is_t && tbl.hit) begin
            o_result.status       = ST_HIT;
            o_result.letter_count = 3'd3;
            o_result.letter_0     = tbl.name[22:16];
            o_result.letter_1     = tbl.name[14:8];
            o_result.letter_2     = tbl.name[6:0];
        end else if (is_t) begin
            o_result.status       = ST_MISS;
            o_result.letter_count = 3'd4;
            o_result.letter_0     = CH_Q;
            o_result.letter_1     = CH_Q;
            o_result.letter_2     = CH_Q;
            o_result.letter_3     = CH_Q;
        end else begin
            o_result.status = ST_NONE;
        end
    end

endmodule

// ===== hdl/rbds_pi_to_call_sign_unit.sv =====
// Converts an RBDS PI code to a North American call sign. One code is taken per clock, back to
// back, unless the input is stalled: a code is registered on acceptance, decoded by
// combinational logic (block range checks, reciprocal multiplies by 676 and 26, and the
// three-letter table) and the result is registered, which raises o_out_valid. A stalled result
// holds the decode register, so the input stalls once both registers are full and is released in
// the same cycle that the result is taken. Status 0 is a K or W call sign, 1 a three-letter table
// hit, 2 a table miss (four '?'), 3 no call sign.
module rbds_pi_to_call_sign_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_pi_code,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [2:0]  o_letter_count,
    output logic [6:0]  o_letter_0,
    output logic [6:0]  o_letter_1,
    output logic [6:0]  o_letter_2,
    output logic [6:0]  o_letter_3
);
    import rbds_pkg::*;

    logic        r_s1_valid;
    logic        n_s1_valid;
    logic [15:0] r_pi;
    logic        r_s2_valid;
    logic        n_s2_valid;
    t_result     r_res;
    t_result     dec_res;
    logic        s2_ready;
    logic        s1_ready;
    logic        in_take;
    logic        s1_move;

    // stage flow control
    assign s2_ready   = !r_s2_valid || !i_out_stall;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign o_in_stall = !s1_ready;
    assign in_take    = i_in_valid && s1_ready;
    assign s1_move    = r_s1_valid && s2_ready;

    assign n_s1_valid = in_take || (r_s1_valid && !s2_ready);
    assign n_s2_valid = s1_move || (r_s2_valid && i_out_stall);

    // decode logic between the two registers
    rbds_decode u_decode (
        .i_pi_code (r_pi),
        .o_result  (dec_res)
    );

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_pi <= i_pi_code;
        end
        if (s1_move) begin
            r_res <= dec_res;
        end
    end

    // output transaction
    assign o_out_valid    = r_s2_valid;
    assign o_status       = r_res.status;
    assign o_letter_count = r_res.letter_count;
    assign o_letter_0     = r_res.letter_0;
    assign o_letter_1     = r_res.letter_1;
    assign o_letter_2     = r_res.letter_2;
    assign o_letter_3     = r_res.letter_3;

    // a decoded code reaches the result register on the next edge whenever that register can take it
    a_s1_to_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s2_ready) |=> o_out_valid)
        else $error("decoded transaction not delivered to result register");

    // no letters exactly when the code is out of range
    a_count_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_letter_count == 3'd0) == (o_status == ST_NONE)))
        else $error("letter count disagrees with status");

    // computed call signs start with k or w
    a_calc_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_CALC) |->
            (o_letter_0 == CH_K || o_letter_0 == CH_W))
        else $error("computed call sign has wrong first letter");

endmodule

// ===== tb/rbds_pi_to_call_sign_unit_tb.sv =====
// self-checking testbench for the rbds pi code to call sign unit
module rbds_pi_to_call_sign_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rbds_pkg::*;

    // divisors that split a block offset into three base-26 letters
    localparam int unsigned DIV_HI  = 676;
    localparam int unsigned DIV_MID = 26;

    localparam int unsigned N_STATIONS  = 72;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned PHASE_ITEMS = 395;
    localparam int unsigned MAX_REPORTS = 10;

    // three-letter stations, each entry is {code, name}
    localparam logic [N_STATIONS*40-1:0] STATION_LIST = {
        16'h99A5, "KBW", 16'h99A6, "KCY", 16'h9990, "KDB", 16'h99A7, "KDF",
        16'h9950, "KEX", 16'h9951, "KFH", 16'h9952, "KFI", 16'h9953, "KGA",
        16'h9991, "KGB", 16'h9954, "KGO", 16'h9955, "KGU", 16'h9956, "KGW",
        16'h9957, "KGY", 16'h99AA, "KHQ", 16'h9958, "KID", 16'h9959, "KIT",
        16'h995A, "KJR", 16'h995B, "KLO", 16'h995C, "KLZ", 16'h995D, "KMA",
        16'h995E, "KMJ", 16'h995F, "KNX", 16'h9960, "KOA", 16'h99AB, "KOB",
        16'h9992, "KOY", 16'h9993, "KPQ", 16'h9964, "KQV", 16'h9994, "KSD",
        16'h9965, "KSL", 16'h9966, "KUJ", 16'h9995, "KUT", 16'h9967, "KVI",
        16'h9968, "KWG", 16'h9996, "KXL", 16'h9997, "KXO", 16'h996B, "KYW",
        16'h9999, "WBT", 16'h996D, "WBZ", 16'h996E, "WDZ", 16'h996F, "WEW",
        16'h999A, "WGH", 16'h9971, "WGL", 16'h9972, "WGN", 16'h9973, "WGR",
        16'h999B, "WGY", 16'h9975, "WHA", 16'h9976, "WHB", 16'h9977, "WHK",
        16'h9978, "WHO", 16'h999C, "WHP", 16'h999D, "WIL", 16'h997A, "WIP",
        16'h99B3, "WIS", 16'h997B, "WJR", 16'h99B4, "WJW", 16'h99B5, "WJZ",
        16'h997C, "WKY", 16'h997D, "WLS", 16'h997E, "WLW", 16'h999E, "WMC",
        16'h999F, "WMT", 16'h9981, "WOC", 16'h99A0, "WOI", 16'h9983, "WOL",
        16'h9984, "WOR", 16'h99A1, "WOW", 16'h99B9, "WRC", 16'h99A2, "WRR",
        16'h99A3, "WSB", 16'h99A4, "WSM", 16'h9988, "WWJ", 16'h9989, "WWL"
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [15:0] i_pi_code = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [2:0]  o_letter_count;
    logic [6:0]  o_letter_0;
    logic [6:0]  o_letter_1;
    logic [6:0]  o_letter_2;
    logic [6:0]  o_letter_3;

    logic [15:0] code_pending[$];
    t_result     sign_expected[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned codes_queued = 0;
    int unsigned signs_seen = 0;
    int unsigned mismatch_count = 0;
    int unsigned status_tally[4] = '{0, 0, 0, 0};
    int unsigned input_stall_cycles = 0;
    int unsigned hold_left = 0;
    logic        hold_req = 1'b0;

    rbds_pi_to_call_sign_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pi_code      (i_pi_code),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_letter_count (o_letter_count),
        .o_letter_0     (o_letter_0),
        .o_letter_1     (o_letter_1),
        .o_letter_2     (o_letter_2),
        .o_letter_3     (o_letter_3)
    );

    // expected call sign for one pi code
    function automatic t_result call_sign_of(input logic [15:0] pi);
        t_result     r;
        int unsigned off;
        logic [39:0] entry;
        r = '0;
        if (pi >= K_FIRST && pi <= W_LAST) begin
            off = (pi < W_FIRST) ? int'(pi - K_FIRST) : int'(pi - W_FIRST);
            r.status       = ST_CALC;
            r.letter_count = 3'd4;
            r.letter_0     = (pi < W_FIRST) ? CH_K : CH_W;
            r.letter_1     = CH_A + 7'(off / DIV_HI);
            r.letter_2     = CH_A + 7'((off % DIV_HI) / DIV_MID);
            r.letter_3     = CH_A + 7'(off % DIV_MID);
        end else if (pi >= T_FIRST && pi <= T_LAST) begin
            // unlisted codes in the table block give four question marks
            r.status       = ST_MISS;
            r.letter_count = 3'd4;
            r.letter_0     = CH_Q;
            r.letter_1     = CH_Q;
            r.letter_2     = CH_Q;
            r.letter_3     = CH_Q;
            for (int i = 0; i < N_STATIONS; i++) begin
                entry = STATION_LIST[i*40 +: 40];
                if (entry[39:24] == pi) begin
                    r.status       = ST_HIT;
                    r.letter_count = 3'd3;
                    r.letter_0     = entry[22:16];
                    r.letter_1     = entry[14:8];
                    r.letter_2     = entry[6:0];
                    r.letter_3     = '0;
                end
            end
        end else begin
            r.status = ST_NONE;
        end
        return r;
    endfunction

    // random code, weighted towards the blocks that produce letters
    function automatic logic [15:0] random_pi();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30)
            return 16'($urandom_range(int'(W_FIRST) - 1, int'(K_FIRST)));
        else if (pick < 60)
            return 16'($urandom_range(int'(W_LAST), int'(W_FIRST)));
        else if (pick < 85)
            return 16'($urandom_range(int'(T_LAST), int'(T_FIRST)));
        return 16'($urandom_range(16'hFFFF));
    endfunction

    task automatic queue_code(input logic [15:0] pi);
        code_pending.push_back(pi);
        codes_queued++;
    endtask

    task automatic drain_pending();
        while (code_pending.size() != 0)
            @(posedge i_clk);
    endtask

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // input driver: one transaction per accepted code
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                sign_expected.push_back(call_sign_of(i_pi_code));
            end
            if (i_in_valid && o_in_stall) begin
                input_stall_cycles++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (code_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_pi_code  <= code_pending.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long output hold, counted down on its own
    always @(posedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left <= LONG_HOLD;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // output monitor and receiver stall
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
            if (o_out_valid && !i_out_stall) begin
                got = '{o_status, o_letter_count, o_letter_0, o_letter_1,
                        o_letter_2, o_letter_3};
                signs_seen++;
                if (sign_expected.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result transaction: status %0d count %0d %h %h %h %h",
                                 got.status, got.letter_count, got.letter_0, got.letter_1,
                                 got.letter_2, got.letter_3);
                end else begin
                    want = sign_expected.pop_front();
                    status_tally[want.status]++;
                    if (got.status !== want.status || got.letter_count !== want.letter_count ||
                        got.letter_0 !== want.letter_0 || got.letter_1 !== want.letter_1 ||
                        got.letter_2 !== want.letter_2 || got.letter_3 !== want.letter_3) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("mismatch on result %0d", signs_seen);
                            $display("  expected: status %0d count %0d letters %h %h %h %h",
                                     want.status, want.letter_count, want.letter_0,
                                     want.letter_1, want.letter_2, want.letter_3);
                            $display("  actual:   status %0d count %0d letters %h %h %h %h",
                                     got.status, got.letter_count, got.letter_0,
                                     got.letter_1, got.letter_2, got.letter_3);
                        end
                    end
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: block edges, letter carries, hits, misses and out of range codes
        queue_code(16'h0000);
        queue_code(16'h0FFF);
        queue_code(K_FIRST);
        queue_code(K_FIRST + 16'd25);
        queue_code(K_FIRST + 16'd26);
        queue_code(K_FIRST + 16'd675);
        queue_code(K_FIRST + 16'd676);
        queue_code(W_FIRST - 16'd1);
        queue_code(W_FIRST);
        queue_code(W_FIRST + 16'd677);
        queue_code(W_LAST);
        queue_code(T_FIRST);
        queue_code(16'h9961);
        queue_code(16'h996C);
        queue_code(16'h99AC);
        queue_code(16'h99B8);
        queue_code(T_LAST);
        queue_code(T_LAST + 16'd1);
        queue_code(16'h5555);
        queue_code(16'hAAAA);
        queue_code(16'hFFFF);
        drain_pending();

        // phase with no idling, opened by a long output hold so the unit backs up
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        for (int n = 0; n < PHASE_ITEMS; n++)
            queue_code(random_pi());
        drain_pending();

        // phases with the sender idling, the receiver stalling, then both
        for (int ph = 1; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 47 : (ph == 3) ? 31 : 0;
            recv_stall_pct = (ph == 2) ? 47 : (ph == 3) ? 31 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_code(random_pi());
            drain_pending();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        while (signs_seen < codes_queued)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d pi codes: %0d computed, %0d table hits, %0d misses, %0d none",
                 codes_queued, status_tally[ST_CALC], status_tally[ST_HIT],
                 status_tally[ST_MISS], status_tally[ST_NONE]);
        $display("input stalled for %0d cycles, longest output hold %0d cycles",
                 input_stall_cycles, LONG_HOLD);
        if (mismatch_count == 0 && sign_expected.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results outstanding",
                     mismatch_count, sign_expected.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/rbds_pkg.sv
hdl/rbds_decode.sv
hdl/rbds_pi_to_call_sign_unit.sv
tb/rbds_pi_to_call_sign_unit_tb.sv
